// ===== sv/ifmt_pkg.sv =====
// shared types, constants and the digit table of the integer formatter
// used by ifmt_conv, ifmt_emit, integer_to_ascii_formatter_top and the testbench; no dependencies

package ifmt_pkg;

	localparam int VALUE_BITS_DEF   = 64;
	localparam int DIGIT_BUFFER_DEF = 64;

	localparam logic [5:0] PREC_MAX  = 6'd40;
	localparam logic [6:0] WIDTH_MAX = 7'd64;

	// conversion codes, unused codes fall back to unsigned decimal
	localparam logic [2:0] FUNC_SDEC = 3'd0;
	localparam logic [2:0] FUNC_UDEC = 3'd1;
	localparam logic [2:0] FUNC_OCT  = 3'd2;
	localparam logic [2:0] FUNC_HEXU = 3'd3;
	localparam logic [2:0] FUNC_HEXL = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [7:0] DIGIT_TABLE [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	// converter status toward the sequencer
	typedef struct packed {
		logic       done;
		logic [6:0] ndig;
	} conv_stat_t;

	// character counts of one word, handed to the emitter
	typedef struct packed {
		logic [6:0] lpad;
		logic       has_sign;
		logic [7:0] sign_char;
		logic [6:0] zpad;
		logic [5:0] zeros;
		logic [6:0] ndig;
		logic [6:0] rpad;
		logic [6:0] total;
		logic       lower;
	} plan_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		c = DIGIT_TABLE[d];
		if (lower && d >= 4'd10) begin
			c = c + CASE_OFS;
		end
		return c;
	endfunction

endpackage

// ===== sv/ifmt_conv.sv =====
// digit extraction: shift/add-3 binary to bcd for decimal, direct slicing for
// octal and hex, then leading zero strip; holds the digit register
// depends on ifmt_pkg

module ifmt_conv #(
	parameter int VALUE_BITS   = ifmt_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_BUFFER = ifmt_pkg::DIGIT_BUFFER_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  ifmt_pkg::base_t         base,
	input  logic [VALUE_BITS-1:0]   mag,
	input  logic                    pop,
	output logic [3:0]              top_digit,
	output ifmt_pkg::conv_stat_t    stat
);

	localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
	localparam int NDIG = (OCT_DIGITS < DIGIT_BUFFER) ? OCT_DIGITS : DIGIT_BUFFER;
	localparam int DW   = NDIG * 4;
	localparam int XW   = DW;
	localparam int CW   = $clog2(NDIG + 1);
	localparam int BW   = $clog2(VALUE_BITS + 1);

	typedef enum logic [1:0] {
		C_IDLE,
		C_DAB,
		C_NORM
	} conv_state_t;

	conv_state_t           state_q;
	logic [BW-1:0]         bits_q;
	logic [CW-1:0]         cnt_q;
	logic [DW-1:0]         dig_q;
	logic [VALUE_BITS-1:0] mag_q;

	logic [XW-1:0] ext;
	logic [DW-1:0] oct_load;
	logic [DW-1:0] hex_load;
	logic [DW-1:0] adj;
	logic [DW-1:0] dig_up;
	logic          strip;

	assign ext = {{(XW - VALUE_BITS){1'b0}}, mag};

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			oct_load[4*i +: 4] = {1'b0, ext[3*i +: 3]};
			hex_load[4*i +: 4] = ext[4*i +: 4];
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
				: dig_q[4*i +: 4];
		end
	end

	assign top_digit = dig_q[DW-1 -: 4];
	assign dig_up    = {dig_q[DW-5:0], 4'b0000};
	// drop a leading zero digit but always keep one
	assign strip     = (cnt_q > CW'(1)) && (top_digit == 4'd0);

	assign stat.done = (state_q == C_NORM) && !strip;
	assign stat.ndig = 7'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			bits_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						if (base == ifmt_pkg::BASE_DEC) begin
							state_q <= C_DAB;
							bits_q  <= BW'(VALUE_BITS);
						end else begin
							state_q <= C_NORM;
							cnt_q   <= CW'(NDIG);
						end
					end
				end
				C_DAB: begin
					bits_q <= bits_q - BW'(1);
					if (bits_q == BW'(1)) begin
						state_q <= C_NORM;
						cnt_q   <= CW'(NDIG);
					end
				end
				C_NORM: begin
					if (strip) begin
						cnt_q <= cnt_q - CW'(1);
					end else begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					mag_q <= mag;
					case (base)
						ifmt_pkg::BASE_DEC: dig_q <= '0;
						ifmt_pkg::BASE_OCT: dig_q <= oct_load;
						default:            dig_q <= hex_load;
					endcase
				end else if (pop) begin
					dig_q <= dig_up;
				end
			end
			C_DAB: begin
				dig_q <= {adj[DW-2:0], mag_q[VALUE_BITS-1]};
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			end
			C_NORM: begin
				if (strip) begin
					dig_q <= dig_up;
				end
			end
			default: begin
				dig_q <= dig_q;
			end
		endcase
	end

endmodule

// ===== sv/ifmt_emit.sv =====
// character emitter: walks padding, sign, zero fill, precision zeros, digits
// and trailing padding, one character per cycle; depends on ifmt_pkg

module ifmt_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ifmt_pkg::plan_t   plan,
	input  logic [3:0]        top_digit,
	output logic              pop,
	output logic              run,
	output logic              char_valid,
	output logic [7:0]        out_char,
	output logic              last
);

	typedef enum logic [2:0] {
		P_LPAD,
		P_SIGN,
		P_ZPAD,
		P_PREC,
		P_DIG,
		P_RPAD
	} pick_t;

	logic [6:0] lpad_q;
	logic       sign_q;
	logic [6:0] zpad_q;
	logic [5:0] prec_q;
	logic [6:0] dig_q;
	logic [6:0] rpad_q;
	logic [6:0] remain_q;
	logic       valid_q;
	logic [7:0] sign_char_q;
	logic       lower_q;
	logic [7:0] char_q;
	logic       last_q;

	pick_t      pick;
	logic [7:0] ch;

	always_comb begin
		if (lpad_q != 7'd0) begin
			pick = P_LPAD;
		end else if (sign_q) begin
			pick = P_SIGN;
		end else if (zpad_q != 7'd0) begin
			pick = P_ZPAD;
		end else if (prec_q != 6'd0) begin
			pick = P_PREC;
		end else if (dig_q != 7'd0) begin
			pick = P_DIG;
		end else begin
			pick = P_RPAD;
		end
	end

	always_comb begin
		case (pick)
			P_LPAD:  ch = ifmt_pkg::CH_SPACE;
			P_SIGN:  ch = sign_char_q;
			P_ZPAD:  ch = ifmt_pkg::CH_ZERO;
			P_PREC:  ch = ifmt_pkg::CH_ZERO;
			P_DIG:   ch = ifmt_pkg::digit_char(top_digit, lower_q);
			default: ch = ifmt_pkg::CH_SPACE;
		endcase
	end

	assign run        = remain_q != 7'd0;
	assign pop        = run && (pick == P_DIG);
	assign char_valid = valid_q;
	assign out_char   = char_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpad_q   <= '0;
			sign_q   <= 1'b0;
			zpad_q   <= '0;
			prec_q   <= '0;
			dig_q    <= '0;
			rpad_q   <= '0;
			remain_q <= '0;
			valid_q  <= 1'b0;
		end else if (start) begin
			lpad_q   <= plan.lpad;
			sign_q   <= plan.has_sign;
			zpad_q   <= plan.zpad;
			prec_q   <= plan.zeros;
			dig_q    <= plan.ndig;
			rpad_q   <= plan.rpad;
			remain_q <= plan.total;
			valid_q  <= 1'b0;
		end else if (run) begin
			remain_q <= remain_q - 7'd1;
			valid_q  <= 1'b1;
			case (pick)
				P_LPAD:  lpad_q <= lpad_q - 7'd1;
				P_SIGN:  sign_q <= 1'b0;
				P_ZPAD:  zpad_q <= zpad_q - 7'd1;
				P_PREC:  prec_q <= prec_q - 6'd1;
				P_DIG:   dig_q  <= dig_q - 7'd1;
				default: rpad_q <= rpad_q - 7'd1;
			endcase
		end else begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sign_char_q <= plan.sign_char;
			lower_q     <= plan.lower;
		end
		if (run) begin
			char_q <= ch;
			last_q <= remain_q == 7'd1;
		end
	end

endmodule

// ===== sv/integer_to_ascii_formatter_top.sv =====
// Integer to ASCII formatter. A word is taken when start is high and busy is
// low; busy stays high until its last character has left. Characters come out
// on out_char, one per cycle while char_valid is high, most significant first,
// with last marking the final one; they cannot be held off. Decimal words run
// through the shift/add-3 converter, octal and hex words skip it; then leading
// zero digits are stripped, keeping at least one, the counts are set up, the
// characters follow (at most 64), and busy drops as the final character leaves.
// A signed zero with a given precision of zero produces no characters and
// leaves busy low.
// depends on ifmt_pkg, ifmt_conv, ifmt_emit

module integer_to_ascii_formatter_top #(
	parameter int VALUE_BITS   = ifmt_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_BUFFER = ifmt_pkg::DIGIT_BUFFER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  func,
	input  logic [63:0] value,
	input  logic [6:0]  min_width,
	input  logic [5:0]  precision,
	input  logic        prec_given,
	input  logic        left_justify,
	input  logic        zero_fill,
	input  logic        plus_flag,
	input  logic        space_flag,
	output logic        busy,
	output logic        char_valid,
	output logic [7:0]  out_char,
	output logic        last
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CONV,
		T_EMIT
	} top_state_t;

	top_state_t state_q;
	logic [6:0] width_q;
	logic [5:0] prec_q;
	logic       has_prec_q;
	logic       left_q;
	logic       zfill_q;
	logic       has_sign_q;
	logic [7:0] sign_char_q;
	logic       lower_q;

	logic                  accept;
	logic [VALUE_BITS-1:0] v;
	logic                  is_signed;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic                  skip;
	ifmt_pkg::base_t       base;
	logic                  has_sign;
	logic [7:0]            sign_char;

	ifmt_pkg::conv_stat_t  cstat;
	logic [3:0]            top_digit;
	logic                  pop;
	logic                  emit_run;
	logic                  emit_start;
	ifmt_pkg::plan_t       plan;

	logic [6:0] zeros7;
	logic [6:0] body;
	logic [6:0] pad;
	logic       zfill_eff;

	assign busy      = state_q != T_IDLE;
	assign accept    = start && !busy;
	assign v         = value[VALUE_BITS-1:0];
	assign is_signed = func == ifmt_pkg::FUNC_SDEC;
	assign neg       = is_signed && v[VALUE_BITS-1];
	assign mag       = neg ? (~v + VALUE_BITS'(1)) : v;
	assign skip      = is_signed && prec_given && (precision == 6'd0) && (v == '0);

	always_comb begin
		case (func)
			ifmt_pkg::FUNC_OCT:  base = ifmt_pkg::BASE_OCT;
			ifmt_pkg::FUNC_HEXU: base = ifmt_pkg::BASE_HEX;
			ifmt_pkg::FUNC_HEXL: base = ifmt_pkg::BASE_HEX;
			default:             base = ifmt_pkg::BASE_DEC;
		endcase
	end

	always_comb begin
		has_sign  = 1'b1;
		sign_char = ifmt_pkg::CH_SPACE;
		if (neg) begin
			sign_char = ifmt_pkg::CH_MINUS;
		end else if (is_signed && plus_flag) begin
			sign_char = ifmt_pkg::CH_PLUS;
		end else if (is_signed && space_flag) begin
			sign_char = ifmt_pkg::CH_SPACE;
		end else begin
			has_sign = 1'b0;
		end
	end

	ifmt_conv #(
		.VALUE_BITS   (VALUE_BITS),
		.DIGIT_BUFFER (DIGIT_BUFFER)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && !skip),
		.base      (base),
		.mag       (mag),
		.pop       (pop),
		.top_digit (top_digit),
		.stat      (cstat)
	);

	// counts of each character group, once the digit count is known
	always_comb begin
		zeros7    = (has_prec_q && ({1'b0, prec_q} > cstat.ndig))
			? {1'b0, prec_q} - cstat.ndig : 7'd0;
		body      = {6'd0, has_sign_q} + zeros7 + cstat.ndig;
		pad       = (width_q > body) ? width_q - body : 7'd0;
		zfill_eff = zfill_q && !left_q && !has_prec_q;

		plan.lpad      = (!left_q && !zfill_eff) ? pad : 7'd0;
		plan.has_sign  = has_sign_q;
		plan.sign_char = sign_char_q;
		plan.zpad      = zfill_eff ? pad : 7'd0;
		plan.zeros     = zeros7[5:0];
		plan.ndig      = cstat.ndig;
		plan.rpad      = left_q ? pad : 7'd0;
		plan.total     = (width_q > body) ? width_q : body;
		plan.lower     = lower_q;
	end

	assign emit_start = (state_q == T_CONV) && cstat.done;

	ifmt_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (emit_start),
		.plan       (plan),
		.top_digit  (top_digit),
		.pop        (pop),
		.run        (emit_run),
		.char_valid (char_valid),
		.out_char   (out_char),
		.last       (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept && !skip) begin
						state_q <= T_CONV;
					end
				end
				T_CONV: begin
					if (cstat.done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (!emit_run) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q     <= (min_width > ifmt_pkg::WIDTH_MAX) ? ifmt_pkg::WIDTH_MAX : min_width;
			prec_q      <= (precision > ifmt_pkg::PREC_MAX) ? ifmt_pkg::PREC_MAX : precision;
			has_prec_q  <= prec_given;
			left_q      <= left_justify;
			zfill_q     <= zero_fill;
			has_sign_q  <= has_sign;
			sign_char_q <= sign_char;
			lower_q     <= func == ifmt_pkg::FUNC_HEXL;
		end
	end

	// characters only leave while a word is in flight
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> busy)
		else $error("character strobe outside a busy word");

	// the characters of one word leave on consecutive cycles
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !last) |=> char_valid)
		else $error("gap inside a word");

	// the final character is never followed straight away by another
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && last) |=> !char_valid)
		else $error("character right after the last one");

	// digits are taken only while emitting
	a_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == T_EMIT))
		else $error("digit taken outside emission");

endmodule

// ===== dv/integer_to_ascii_formatter_top_tb.sv =====
// self-checking testbench of integer_to_ascii_formatter_top: a directed table, then random words
// every accepted word is compared char by char, against its typed text or a local predictor
// depends on ifmt_pkg and integer_to_ascii_formatter_top

module integer_to_ascii_formatter_top_tb;

	localparam int RANDOM_WORDS   = 400;
	localparam int QUIET_TAIL     = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;

	localparam logic [127:0] DIGIT_CHARS = "0123456789ABCDEF";
	localparam logic [7:0]   LOWER_OFS   = 8'h20;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] value;
		logic [6:0]  min_width;
		logic [5:0]  precision;
		logic        prec_given;
		logic        left_justify;
		logic        zero_fill;
		logic        plus_flag;
		logic        space_flag;
	} fmt_word_t;

	typedef struct {
		fmt_word_t w;
		bit        typed;
		string     text;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  func = '0;
	logic [63:0] value = '0;
	logic [6:0]  min_width = '0;
	logic [5:0]  precision = '0;
	logic        prec_given = 1'b0;
	logic        left_justify = 1'b0;
	logic        zero_fill = 1'b0;
	logic        plus_flag = 1'b0;
	logic        space_flag = 1'b0;
	logic        busy;
	logic        char_valid;
	logic [7:0]  out_char;
	logic        last;

	// text typed into the table for the word now on the inputs
	bit          row_typed = 1'b0;
	string       row_text = "";

	char_beat_t  formatted_chars [$];
	stim_row_t   directed_rows [$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;

	integer_to_ascii_formatter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.value        (value),
		.min_width    (min_width),
		.precision    (precision),
		.prec_given   (prec_given),
		.left_justify (left_justify),
		.zero_fill    (zero_fill),
		.plus_flag    (plus_flag),
		.space_flag   (space_flag),
		.busy         (busy),
		.char_valid   (char_valid),
		.out_char     (out_char),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// printf-style integer conversion of one word, chars queued most significant first
	function automatic void format_word(input fmt_word_t w);
		logic [63:0] mag;
		logic [7:0]  digs [64];
		logic [7:0]  chars [$];
		logic [7:0]  sign_ch;
		logic [3:0]  d;
		logic        is_signed, neg, lc, zfill, shows_sign;
		int unsigned base, ndig, nzero, body, pad, width, prec;
		is_signed = (w.func == ifmt_pkg::FUNC_SDEC);
		width = (w.min_width > ifmt_pkg::WIDTH_MAX) ? ifmt_pkg::WIDTH_MAX : w.min_width;
		prec = (w.precision > ifmt_pkg::PREC_MAX) ? ifmt_pkg::PREC_MAX : w.precision;
		case (w.func)
			ifmt_pkg::FUNC_OCT: base = 8;
			ifmt_pkg::FUNC_HEXU, ifmt_pkg::FUNC_HEXL: base = 16;
			default: base = 10;
		endcase
		lc = (w.func == ifmt_pkg::FUNC_HEXL);
		neg = is_signed && w.value[63];
		mag = neg ? -w.value : w.value;
		// signed zero with an explicit zero precision prints nothing at all
		if (is_signed && w.prec_given && prec == 0 && w.value == '0) begin
			return;
		end
		ndig = 0;
		do begin
			d = 4'(mag % base);
			digs[ndig] = DIGIT_CHARS[8 * (15 - d) +: 8];
			if (lc && d >= 4'd10) begin
				digs[ndig] = digs[ndig] + LOWER_OFS;
			end
			ndig++;
			mag = mag / base;
		end while (mag != '0);
		shows_sign = neg || (is_signed && (w.plus_flag || w.space_flag));
		sign_ch = neg ? ifmt_pkg::CH_MINUS
			: (w.plus_flag ? ifmt_pkg::CH_PLUS : ifmt_pkg::CH_SPACE);
		zfill = w.zero_fill && !w.left_justify && !w.prec_given;
		nzero = (w.prec_given && prec > ndig) ? prec - ndig : 0;
		body = (shows_sign ? 1 : 0) + nzero + ndig;
		pad = (width > body) ? width - body : 0;
		if (!w.left_justify && !zfill) begin
			repeat (pad) chars.push_back(ifmt_pkg::CH_SPACE);
		end
		if (shows_sign) begin
			chars.push_back(sign_ch);
		end
		if (zfill) begin
			repeat (pad) chars.push_back(ifmt_pkg::CH_ZERO);
		end
		repeat (nzero) chars.push_back(ifmt_pkg::CH_ZERO);
		for (int i = ndig; i > 0; i--) begin
			chars.push_back(digs[i - 1]);
		end
		if (w.left_justify) begin
			repeat (pad) chars.push_back(ifmt_pkg::CH_SPACE);
		end
		foreach (chars[i]) begin
			formatted_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
		end
	endfunction

	function automatic stim_row_t mk_row(input logic [2:0] fn, input logic [63:0] val,
			input logic [6:0] wid, input logic [5:0] prec, input int hp, input int lj,
			input int zf, input int pf, input int sf, input int typed, input string text);
		stim_row_t r;
		r.w = '{func: fn, value: val, min_width: wid, precision: prec,
			prec_given: 1'(hp), left_justify: 1'(lj), zero_fill: 1'(zf),
			plus_flag: 1'(pf), space_flag: 1'(sf)};
		r.typed = 1'(typed);
		r.text = text;
		return r;
	endfunction

	function automatic fmt_word_t random_word();
		fmt_word_t w;
		w.func = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		case ($urandom_range(0, 5))
			0: w.value = {$urandom, $urandom};
			1: w.value = 64'($urandom_range(0, 999));
			2: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
			3: w.value = -({$urandom, $urandom} >> $urandom_range(1, 63));
			4: begin
				case ($urandom_range(0, 3))
					0: w.value = 64'd1;
					1: w.value = '1;
					2: w.value = 64'h8000_0000_0000_0000;
					default: w.value = 64'h7FFF_FFFF_FFFF_FFFF;
				endcase
			end
			default: w.value = '0;
		endcase
		w.min_width = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, 24));
		w.precision = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 12));
		w.prec_given = 1'($urandom);
		w.left_justify = 1'($urandom);
		w.zero_fill = 1'($urandom);
		w.plus_flag = 1'($urandom);
		w.space_flag = 1'($urandom);
		return w;
	endfunction

	// entered just after a falling edge, returns just after the falling edge past acceptance
	task automatic issue_word(input fmt_word_t w, input bit typed, input string text,
			input int gap);
		if (gap > 0) begin
			// idle while the block is ready, not while it is still busy
			start <= 1'b0;
			while (busy) @(negedge clk);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		func <= w.func;
		value <= w.value;
		min_width <= w.min_width;
		precision <= w.precision;
		prec_given <= w.prec_given;
		left_justify <= w.left_justify;
		zero_fill <= w.zero_fill;
		plus_flag <= w.plus_flag;
		space_flag <= w.space_flag;
		row_typed <= typed;
		row_text <= text;
		// busy is stable between rising edges, so the next edge with busy low takes the word
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	// checks chars first, then predicts the word taken at the same edge
	always @(posedge clk) begin : char_monitor
		char_beat_t want;
		fmt_word_t  taken;
		if (arst_n) begin
			if (char_valid || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (char_valid) begin
				if (formatted_chars.size() == 0) begin
					$display("%0t: unexpected char %h last %b, expected none",
						$time, out_char, last);
					mismatch_count++;
				end else begin
					want = formatted_chars.pop_front();
					if (out_char !== want.ch || last !== want.last) begin
						$display("%0t: char mismatch: expected %h last %b, actual %h last %b",
							$time, want.ch, want.last, out_char, last);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				if (row_typed) begin
					for (int i = 0; i < row_text.len(); i++) begin
						formatted_chars.push_back('{ch: row_text[i],
							last: (i == row_text.len() - 1)});
					end
				end else begin
					taken = '{func: func, value: value, min_width: min_width,
						precision: precision, prec_given: prec_given,
						left_justify: left_justify, zero_fill: zero_fill,
						plus_flag: plus_flag, space_flag: space_flag};
					format_word(taken);
				end
			end
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		bit calm;
		int gap;
		//                    func       value                   wid   prec hp lj zf pf sf typed
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd0, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "0"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd0, 7'd10, 6'd0,
			1, 0, 0, 1, 0, 1, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'h8000_0000_0000_0000, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "-9223372036854775808"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "9223372036854775807"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, '1, 7'd0, 6'd0,
			0, 0, 0, 1, 0, 1, "-1"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_UDEC, '1, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "18446744073709551615"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_OCT, '1, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "1777777777777777777777"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_HEXU, '1, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "FFFFFFFFFFFFFFFF"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_HEXL, 64'hDEAD_BEEF, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "deadbeef"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_HEXL, 64'd0, 7'd0, 6'd0,
			0, 0, 0, 0, 0, 1, "0"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_UDEC, 64'd0, 7'd0, 6'd0,
			1, 0, 0, 0, 0, 1, "0"));
		// unused codes fall back to unsigned decimal, sign flags ignored
		directed_rows.push_back(mk_row(3'd5, 64'd123, 7'd0, 6'd0, 0, 0, 0, 0, 0, 1, "123"));
		directed_rows.push_back(mk_row(3'd7, 64'd0, 7'd0, 6'd0, 0, 0, 0, 1, 1, 1, "0"));
		directed_rows.push_back(mk_row(3'd6, 64'd9, 7'd3, 6'd0, 0, 0, 0, 1, 0, 0, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd5, 7'd0, 6'd0,
			0, 0, 0, 1, 0, 1, "+5"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd5, 7'd0, 6'd0,
			0, 0, 0, 0, 1, 1, " 5"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd5, 7'd0, 6'd0,
			0, 0, 0, 1, 1, 1, "+5"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, -64'd5, 7'd0, 6'd0,
			0, 0, 0, 0, 1, 1, "-5"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, -64'd5, 7'd6, 6'd0,
			0, 0, 1, 0, 0, 1, "-00005"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd42, 7'd6, 6'd0,
			0, 1, 1, 0, 0, 1, "42    "));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'd42, 7'd6, 6'd3,
			1, 0, 1, 0, 0, 1, "   042"));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_OCT, 64'd8, 7'd5, 6'd0,
			0, 0, 1, 0, 0, 1, "00010"));
		// saturation of precision and width, and the widest fields
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_UDEC, 64'd7, 7'd0, 6'd63,
			1, 0, 0, 0, 0, 0, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_UDEC, 64'd1, 7'd127, 6'd0,
			0, 0, 0, 0, 0, 0, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, -64'd1, 7'd64, 6'd40,
			1, 1, 0, 0, 0, 0, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_SDEC, 64'h8000_0000_0000_0000, 7'd64, 6'd0,
			0, 0, 1, 0, 0, 0, ""));
		directed_rows.push_back(mk_row(ifmt_pkg::FUNC_HEXU, 64'hABC, 7'd10, 6'd5,
			1, 1, 1, 1, 1, 0, ""));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			issue_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].text, 0);
		end

		calm = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 15) == 0) begin
				calm = !calm;
			end
			gap = 0;
			if (!calm && n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 11);
			end
			issue_word(random_word(), 1'b0, "", gap);
		end
		start <= 1'b0;

		while (formatted_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ifmt_pkg.sv
sv/ifmt_conv.sv
sv/ifmt_emit.sv
sv/integer_to_ascii_formatter_top.sv
dv/integer_to_ascii_formatter_top_tb.sv
